// ----- design/protected_header_checker_assert.svh -----
// ---------------------------------------------------------------------------
// protected_header_checker assertion macros
// Clocked property wrappers used by the checker's RTL file protected_header_checker.sv.
// ---------------------------------------------------------------------------
`ifndef PROTECTED_HEADER_CHECKER_ASSERT_SVH
`define PROTECTED_HEADER_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/phc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// phc_pkg
// Header layout, error codes and CRC-32 byte update for the header checker.
// ---------------------------------------------------------------------------
package phc_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
  localparam logic [7:0]  HDR_VERSION = 8'd1;
  localparam logic [7:0]  HDR_LEN     = 8'd32;
  localparam logic [7:0]  MAGIC [4]   = '{8'h4C, 8'h45, 8'h4E, 8'h43};

  // byte offsets within the header
  localparam logic [4:0] POS_MAGIC_LO = 5'd0;
  localparam logic [4:0] POS_MAGIC_HI = 5'd3;
  localparam logic [4:0] POS_VERSION  = 5'd4;
  localparam logic [4:0] POS_HDRLEN   = 5'd5;
  localparam logic [4:0] POS_CHUNK_LO = 5'd6;
  localparam logic [4:0] POS_CHUNK_HI = 5'd7;
  localparam logic [4:0] POS_SIZE_LO  = 5'd8;
  localparam logic [4:0] POS_SIZE_HI  = 5'd11;
  localparam logic [4:0] POS_SEED_LO  = 5'd12;
  localparam logic [4:0] POS_SEED_HI  = 5'd19;
  localparam logic [4:0] POS_TAIL_LO  = 5'd20;
  localparam logic [4:0] POS_TAIL_HI  = 5'd23;
  localparam logic [4:0] POS_RSVD_LO  = 5'd24;
  localparam logic [4:0] POS_RSVD_HI  = 5'd27;
  localparam logic [4:0] POS_CRC_LO   = 5'd28;
  localparam logic [4:0] POS_LAST     = 5'd31;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_MAGIC     = 4'd1,
    ERR_VERSION   = 4'd2,
    ERR_HDRLEN    = 4'd3,
    ERR_CHUNK     = 4'd4,
    ERR_RESERVED  = 4'd5,
    ERR_CRC       = 4'd6,
    ERR_ZERO_SIZE = 4'd7,
    ERR_OVERFLOW  = 4'd8,
    ERR_SEED      = 4'd9
  } err_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

// ----- design/phc_size_check.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// phc_size_check
// Overflow test of the physical file size as one compare of the plaintext
// size against the largest size that still fits.
// ---------------------------------------------------------------------------
module phc_size_check #(
  parameter int CHUNK_BYTES = 4096,
  parameter int TAG_BYTES   = 16,
  parameter int SIZE_BITS   = 32
) (
  input  logic [31:0] size_in,
  output logic        overflow
);

  // header + size + chunks * tag bytes, for a nonzero size
  function automatic logic [63:0] phys_size(logic [63:0] s);
    logic [63:0] chunks;
    chunks = 64'd1 + (s - 64'd1) / 64'(CHUNK_BYTES);
    return 64'(phc_pkg::HDR_LEN) + s + chunks * 64'(TAG_BYTES);
  endfunction

  // the physical size grows with the plaintext size, so search once for the
  // largest plaintext size whose physical size fits in SIZE_BITS bits
  function automatic logic [31:0] max_fit_size();
    logic [63:0] limit;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    if (SIZE_BITS >= 64) begin
      limit = '1;
    end else begin
      limit = (64'd1 << SIZE_BITS) - 64'd1;
    end
    lo = 64'd1;
    hi = 64'hFFFF_FFFF;
    if (phys_size(hi) <= limit) begin
      lo = hi;
    end
    for (int k = 0; k < 33; k++) begin
      if (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        if (phys_size(mid) <= limit) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
    end
    return lo[31:0];
  endfunction

  localparam logic [31:0] MAX_FIT = max_fit_size();

  assign overflow = (size_in > MAX_FIT);

endmodule

// ----- design/protected_header_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// protected_header_checker
// Byte-stream checker for the 32-byte encrypted-file header.
// ---------------------------------------------------------------------------
// Takes one header byte per cycle (in_tuser high marks offset 0 and restarts
// the parse) and, once offset 31 is through the parse stage, presents one
// result: pass flag, first error code, plaintext size and the 64-bit nonce
// seed. Each byte passes through an input register and a single stage that
// updates the CRC-32 and field checks; the result sits in its own output
// register, so bytes of the next header keep flowing while it waits. The
// size overflow test is one compare of the plaintext size against the
// largest size whose physical size fits, worked out when the block is built,
// so every stage stays at one byte-wide CRC update.
// Sustained rate: one byte per cycle; only a second result that finds the
// previous one still untaken stalls the input.
// ---------------------------------------------------------------------------
`include "protected_header_checker_assert.svh"

module protected_header_checker #(
  parameter int CHUNK_BYTES = 4096,
  parameter int TAG_BYTES   = 16,
  parameter int SIZE_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] hdr_byte
  input  logic         in_tuser,   // [0] first
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // [0] valid_res, [4:1] error_code,
                                   // [36:5] plaintext_size, [100:37] nonce_seed
);

  localparam logic [15:0] CHUNK16 = 16'(CHUNK_BYTES);

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_first_r;

  // parse state
  logic [4:0]          pos_r;
  logic [31:0]         crc_r, crc_nxt;
  logic [31:0]         scrc_r, scrc_nxt;
  phc_pkg::err_t       err_r, err_nxt;
  logic [31:0]         size_r, size_nxt;
  logic [63:0]         seed_r, seed_nxt;
  logic [7:0]          chunk_lo_r, chunk_lo_nxt;
  logic                tail_nz_r, tail_nz_nxt;

  // result register
  logic                out_valid_r;
  logic [103:0]        out_data_r;

  logic                restart, emit, adv, overflow;
  logic [4:0]          p, seed_off;
  logic [7:0]          b;
  phc_pkg::err_t       code;

  assign b        = in_byte_r;
  assign restart  = in_first_r || (pos_r == phc_pkg::POS_MAGIC_LO);
  assign p        = in_first_r ? phc_pkg::POS_MAGIC_LO : pos_r;
  assign emit     = (p == phc_pkg::POS_LAST);
  assign adv      = in_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign seed_off = p - phc_pkg::POS_SEED_LO;

  always_comb begin
    crc_nxt      = restart ? phc_pkg::CRC_PRESET : crc_r;
    scrc_nxt     = restart ? 32'd0 : scrc_r;
    err_nxt      = restart ? phc_pkg::ERR_NONE : err_r;
    size_nxt     = restart ? 32'd0 : size_r;
    seed_nxt     = restart ? 64'd0 : seed_r;
    chunk_lo_nxt = restart ? 8'd0 : chunk_lo_r;
    tail_nz_nxt  = restart ? 1'b0 : tail_nz_r;

    if (p < phc_pkg::POS_CRC_LO) begin
      crc_nxt = phc_pkg::crc_byte(crc_nxt, b);
    end

    // only the first field error sticks
    case (p) inside
      [phc_pkg::POS_MAGIC_LO:phc_pkg::POS_MAGIC_HI]: begin
        if (b != phc_pkg::MAGIC[p[1:0]] && err_nxt == phc_pkg::ERR_NONE) begin
          err_nxt = phc_pkg::ERR_MAGIC;
        end
      end
      phc_pkg::POS_VERSION: begin
        if (b != phc_pkg::HDR_VERSION && err_nxt == phc_pkg::ERR_NONE) begin
          err_nxt = phc_pkg::ERR_VERSION;
        end
      end
      phc_pkg::POS_HDRLEN: begin
        if (b != phc_pkg::HDR_LEN && err_nxt == phc_pkg::ERR_NONE) begin
          err_nxt = phc_pkg::ERR_HDRLEN;
        end
      end
      phc_pkg::POS_CHUNK_LO: begin
        chunk_lo_nxt = b;
      end
      phc_pkg::POS_CHUNK_HI: begin
        if ({b, chunk_lo_nxt} != CHUNK16 && err_nxt == phc_pkg::ERR_NONE) begin
          err_nxt = phc_pkg::ERR_CHUNK;
        end
      end
      [phc_pkg::POS_SIZE_LO:phc_pkg::POS_SIZE_HI]: begin
        size_nxt[8 * p[1:0] +: 8] = b;
      end
      [phc_pkg::POS_SEED_LO:phc_pkg::POS_SEED_HI]: begin
        seed_nxt[8 * seed_off[2:0] +: 8] = b;
      end
      [phc_pkg::POS_TAIL_LO:phc_pkg::POS_TAIL_HI]: begin
        if (b != 8'd0) begin
          tail_nz_nxt = 1'b1;
        end
      end
      [phc_pkg::POS_RSVD_LO:phc_pkg::POS_RSVD_HI]: begin
        if (b != 8'd0 && err_nxt == phc_pkg::ERR_NONE) begin
          err_nxt = phc_pkg::ERR_RESERVED;
        end
      end
      default: begin
        scrc_nxt[8 * p[1:0] +: 8] = b;
      end
    endcase
  end

  // final verdict, valid only on the last header byte
  always_comb begin
    code = err_nxt;
    if (code == phc_pkg::ERR_NONE && scrc_nxt != ~crc_nxt) begin
      code = phc_pkg::ERR_CRC;
    end
    if (code == phc_pkg::ERR_NONE && size_nxt == 32'd0) begin
      code = phc_pkg::ERR_ZERO_SIZE;
    end
    if (code == phc_pkg::ERR_NONE && overflow) begin
      code = phc_pkg::ERR_OVERFLOW;
    end
    if (code == phc_pkg::ERR_NONE && (seed_nxt == 64'd0 || tail_nz_nxt)) begin
      code = phc_pkg::ERR_SEED;
    end
  end

  phc_size_check #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .TAG_BYTES   (TAG_BYTES),
    .SIZE_BITS   (SIZE_BITS)
  ) u_size_check (
    .size_in  (size_nxt),
    .overflow (overflow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      pos_r       <= phc_pkg::POS_MAGIC_LO;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        pos_r <= p + 5'd1;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser;
    end
    if (adv) begin
      crc_r      <= crc_nxt;
      scrc_r     <= scrc_nxt;
      err_r      <= err_nxt;
      size_r     <= size_nxt;
      seed_r     <= seed_nxt;
      chunk_lo_r <= chunk_lo_nxt;
      tail_nz_r  <= tail_nz_nxt;
    end
    if (adv && emit) begin
      out_data_r <= {3'd0, seed_nxt, size_nxt, code, code == phc_pkg::ERR_NONE};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PHC_ASSERT_IMP(a_pass_flag, out_tvalid,
                  out_tdata[0] == (out_tdata[4:1] == phc_pkg::ERR_NONE),
                  "pass flag disagrees with error code")
  `PHC_ASSERT_IMP(a_code_range, out_tvalid, out_tdata[4:1] <= phc_pkg::ERR_SEED,
                  "error code out of range")
  `PHC_ASSERT_NXT(a_pos_step, adv && !restart && pos_r != phc_pkg::POS_LAST,
                  pos_r == $past(pos_r) + 5'd1, "byte position skipped")
  `PHC_ASSERT_NXT(a_emit_load, adv && emit,
                  out_tvalid && out_tdata[36:5] == $past(size_nxt),
                  "result not loaded on last byte")
  `PHC_ASSERT_IMP(a_no_clobber, out_valid_r && !out_tready, !(adv && emit),
                  "pending result overwritten")

endmodule
